[sv/mp3_duration_estimator_macros.svh]
// Assertion helpers used by the checker file
`ifndef MP3_DURATION_ESTIMATOR_MACROS_SVH
`define MP3_DURATION_ESTIMATOR_MACROS_SVH

// same-cycle implication, held off while in reset
`define MDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mde check failed");

// next-cycle implication, held off while in reset
`define MDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mde check failed");

`endif

[sv/mde_pkg.sv]
package mde_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int AUD_W = 29;          // ID3 syncsafe size (28 bits) plus 10
  localparam int DUR_W = 31;
  localparam int MUL_W = 43;          // 32-bit frame count times 11-bit samples per frame

  localparam logic [1:0] METH_FAIL = 2'd0;
  localparam logic [1:0] METH_TAG  = 2'd1;
  localparam logic [1:0] METH_CBR  = 2'd2;

  typedef enum logic [2:0] {
    PH_SCAN, PH_HDR, PH_BODY, PH_DONE, PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    ST_STREAM, ST_DIV, ST_OUT
  } top_state_t;

  // work handed from the byte parser to the divider
  typedef struct packed {
    logic [1:0]  method;
    logic [31:0] frame_total;
    logic [10:0] frame_samples;
    logic [18:0] divisor;
  } job_t;

  localparam logic [8:0] KBPS_V2_L23 [16] = '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0};
  localparam logic [8:0] KBPS_V2_L1  [16] = '{0,32,48,56,64,80,96,112,128,144,160,176,192,224,256,0};
  localparam logic [8:0] KBPS_V1_L3  [16] = '{0,32,40,48,56,64,80,96,112,128,160,192,224,256,320,0};
  localparam logic [8:0] KBPS_V1_L2  [16] = '{0,32,48,56,64,80,96,112,128,160,192,224,256,320,384,0};
  localparam logic [8:0] KBPS_V1_L1  [16] = '{0,32,64,96,128,160,192,224,256,288,320,352,384,416,448,0};

  // bitrate in kbit/s; lay is the header layer code (3 = Layer I)
  function automatic logic [8:0] kbps_lookup(logic mpeg1, logic [1:0] lay, logic [3:0] bri);
    logic [8:0] k;
    k = 9'd0;
    if (mpeg1) begin
      unique case (lay)
        2'd1:    k = KBPS_V1_L3[bri];
        2'd2:    k = KBPS_V1_L2[bri];
        2'd3:    k = KBPS_V1_L1[bri];
        default: k = 9'd0;
      endcase
    end else begin
      unique case (lay)
        2'd1, 2'd2: k = KBPS_V2_L23[bri];
        2'd3:       k = KBPS_V2_L1[bri];
        default:    k = 9'd0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [15:0] rate_lookup(logic [1:0] ver, logic [1:0] sri);
    logic [15:0] r;
    r = 16'd0;
    unique case (sri)
      2'd0:    r = (ver == 2'd3) ? 16'd44100 : ((ver == 2'd2) ? 16'd22050 : 16'd11025);
      2'd1:    r = (ver == 2'd3) ? 16'd48000 : ((ver == 2'd2) ? 16'd24000 : 16'd12000);
      2'd2:    r = (ver == 2'd3) ? 16'd32000 : ((ver == 2'd2) ? 16'd16000 : 16'd8000);
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] spf_lookup(logic mpeg1, logic [1:0] lay);
    logic [10:0] s;
    s = 11'd0;
    unique case (lay)
      2'd1:    s = mpeg1 ? 11'd1152 : 11'd576;
      2'd2:    s = 11'd1152;
      2'd3:    s = 11'd384;
      default: s = 11'd0;
    endcase
    return s;
  endfunction

endpackage

[sv/mp3_duration_estimator.sv]
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_data_byte, in_last_byte
// out     | output    | out_valid, out_ready, out_duration_seconds, out_method
//
// One byte a cycle while streaming; the byte parser takes one word a cycle.
// After the last byte the divider is loaded and runs max(43, SIZE_BITS+3) restoring
// steps; then the result word is registered and out_valid rises.
// in_ready is low from the last byte until the result word is taken.
// rst_n is synchronous, active low; after each file the block is back in reset state.
module mp3_duration_estimator #(
  parameter int SIZE_BITS = mde_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_duration_seconds,
  output logic [1:0]  out_method
);
  import mde_pkg::*;

  top_state_t           state_r, state_nxt;
  logic                 step, start, done;
  job_t                 job;
  logic [SIZE_BITS-1:0] span;
  logic [30:0]          quotient;
  logic [30:0]          dur_r;
  logic [1:0]           meth_r;

  assign step = in_valid && in_ready;

  mde_parser #(.SIZE_BITS(SIZE_BITS)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .start     (start),
    .job       (job),
    .span      (span)
  );

  mde_divider #(.SIZE_BITS(SIZE_BITS)) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .job      (job),
    .span     (span),
    .done     (done),
    .quotient (quotient)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_STREAM: begin
        in_ready = 1'b1;
        if (in_valid && in_last_byte) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_STREAM;
      end
      default: state_nxt = ST_STREAM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_STREAM;
    else        state_r <= state_nxt;
  end

  // result word
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && done) begin
      dur_r  <= (job.method == METH_FAIL) ? 31'd0 : quotient;
      meth_r <= job.method;
    end
  end

  assign out_duration_seconds = dur_r;
  assign out_method           = meth_r;

endmodule

[sv/mde_parser.sv]
module mde_parser #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  start,
  output mde_pkg::job_t         job,
  output logic [SIZE_BITS-1:0]  span
);
  import mde_pkg::*;

  localparam int CW = (SIZE_BITS > AUD_W) ? SIZE_BITS : AUD_W;

  phase_t                phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]  bytes_r, bytes_nxt;
  logic [AUD_W-1:0]      aud_r, aud_nxt;
  logic [7:0]            prev_r, prev_nxt;
  logic [23:0]           hdr_r, hdr_nxt;
  logic [5:0]            off_r, off_nxt;
  logic [31:0]           recent_r, recent_nxt;
  logic                  xflag_r, xflag_nxt;
  logic [31:0]           ft_r, ft_nxt;
  logic                  id3_r, id3_nxt;
  logic                  xhit_r, xhit_nxt;
  logic                  vhit_r, vhit_nxt;
  logic                  start_r;
  job_t                  job_r, job_nxt;
  logic [SIZE_BITS-1:0]  span_r, span_nxt;

  logic [SIZE_BITS-1:0]  pos;
  logic                  id3_hit, scan_ok, mono, mpeg1, bad;
  logic [5:0]            xo;
  logic [CW-1:0]         pos_x, aud_x, bytes_x;
  logic [8:0]            kbps;
  logic [15:0]           rate;
  logic [10:0]           spf;

  // per-word parse, one word a cycle while step is high
  always_comb begin
    pos        = bytes_r;
    recent_nxt = {recent_r[23:0], data_byte};
    bytes_nxt  = (&bytes_r) ? bytes_r : bytes_r + SIZE_BITS'(1);
    id3_hit    = (pos == SIZE_BITS'(2)) && (recent_nxt[23:0] == 24'h494433);
    id3_nxt    = id3_r | id3_hit;
    aud_nxt    = aud_r;
    if (id3_nxt && pos >= SIZE_BITS'(6) && pos <= SIZE_BITS'(9)) begin
      aud_nxt = {aud_r[AUD_W-8:0], data_byte[6:0]};
      if (pos == SIZE_BITS'(9)) aud_nxt = aud_nxt + AUD_W'(10);
    end
    pos_x   = CW'(pos);
    aud_x   = CW'(aud_nxt);
    scan_ok = !id3_nxt || (pos >= SIZE_BITS'(10) && pos_x >= aud_x);

    phase_nxt = id3_hit ? PH_SCAN : phase_r;
    prev_nxt  = id3_hit ? 8'd0 : prev_r;
    hdr_nxt   = hdr_r;
    off_nxt   = off_r;
    xflag_nxt = xflag_r;
    ft_nxt    = ft_r;
    xhit_nxt  = xhit_r;
    vhit_nxt  = vhit_r;
    mono      = hdr_r[7:6] == 2'd3;
    mpeg1     = hdr_r[20:19] == 2'd3;
    xo        = mpeg1 ? (mono ? 6'd21 : 6'd36) : (mono ? 6'd13 : 6'd21);
    bad       = 1'b0;

    unique case (phase_nxt)
      PH_SCAN: begin
        if (scan_ok) begin
          if (prev_nxt == 8'hFF && data_byte[7:5] == 3'b111) begin
            hdr_nxt   = {data_byte, 16'h0};
            off_nxt   = 6'd1;
            phase_nxt = PH_HDR;
          end
          prev_nxt = data_byte;
        end
      end
      PH_HDR: begin
        off_nxt = off_r + 6'd1;
        if (off_nxt == 6'd2) begin
          hdr_nxt[15:8] = data_byte;
        end else begin
          hdr_nxt[7:0] = data_byte;
          bad = (hdr_nxt[20:19] == 2'd1) || (hdr_nxt[18:17] == 2'd0) ||
                (hdr_nxt[15:12] == 4'd0) || (hdr_nxt[15:12] == 4'd15) ||
                (hdr_nxt[11:10] == 2'd3);
          phase_nxt = bad ? PH_FAIL : PH_BODY;
        end
      end
      PH_BODY: begin
        off_nxt = off_r + 6'd1;
        if (off_nxt == xo + 6'd3)
          xhit_nxt = (recent_nxt == 32'h58696E67) || (recent_nxt == 32'h496E666F);
        if (off_nxt == xo + 6'd7 && xhit_nxt) xflag_nxt = data_byte[0];
        if (off_nxt == xo + 6'd11 && xhit_nxt && xflag_nxt) ft_nxt = recent_nxt;
        if (off_nxt == 6'd39) vhit_nxt = recent_nxt == 32'h56425249;
        if (off_nxt == 6'd53) begin
          if (ft_nxt == 32'd0 && vhit_nxt) ft_nxt = recent_nxt;
          phase_nxt = PH_DONE;
        end
      end
      default: ;
    endcase

    // result set-up for the last word
    kbps    = kbps_lookup(hdr_nxt[20:19] == 2'd3, hdr_nxt[18:17], hdr_nxt[15:12]);
    rate    = rate_lookup(hdr_nxt[20:19], hdr_nxt[11:10]);
    spf     = spf_lookup(hdr_nxt[20:19] == 2'd3, hdr_nxt[18:17]);
    bytes_x = CW'(bytes_nxt);
    span_nxt = (bytes_x >= aud_x) ? SIZE_BITS'(bytes_x - aud_x) : '0;
    job_nxt.frame_total   = ft_nxt;
    job_nxt.frame_samples = spf;
    if (bytes_nxt >= SIZE_BITS'(10) && (phase_nxt == PH_BODY || phase_nxt == PH_DONE)) begin
      job_nxt.method = (ft_nxt != 32'd0) ? METH_TAG : METH_CBR;
    end else begin
      job_nxt.method = METH_FAIL;
    end
    job_nxt.divisor = (job_nxt.method == METH_TAG) ? 19'(rate) : 19'(kbps) * 19'd1000;
  end

  // parse state, cleared after each file
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r  <= PH_SCAN;
      bytes_r  <= '0;
      aud_r    <= '0;
      prev_r   <= '0;
      hdr_r    <= '0;
      off_r    <= '0;
      recent_r <= '0;
      xflag_r  <= 1'b0;
      ft_r     <= '0;
      id3_r    <= 1'b0;
      xhit_r   <= 1'b0;
      vhit_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      bytes_r  <= bytes_nxt;
      aud_r    <= aud_nxt;
      prev_r   <= prev_nxt;
      hdr_r    <= hdr_nxt;
      off_r    <= off_nxt;
      recent_r <= recent_nxt;
      xflag_r  <= xflag_nxt;
      ft_r     <= ft_nxt;
      id3_r    <= id3_nxt;
      xhit_r   <= xhit_nxt;
      vhit_r   <= vhit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) start_r <= 1'b0;
    else        start_r <= step && last_byte;
  end

  always_ff @(posedge clk) begin
    if (step && last_byte) begin
      job_r  <= job_nxt;
      span_r <= span_nxt;
    end
  end

  assign start = start_r;
  assign job   = job_r;
  assign span  = span_r;

endmodule

[sv/mde_divider.sv]
module mde_divider #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  mde_pkg::job_t         job,
  input  logic [SIZE_BITS-1:0]  span,
  output logic                  done,
  output logic [30:0]           quotient
);
  import mde_pkg::*;

  localparam int DW   = (SIZE_BITS + 3 > MUL_W) ? SIZE_BITS + 3 : MUL_W;
  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   q_r, q_nxt;
  logic [19:0]     r_r, r_nxt;
  logic [18:0]     d_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [19:0]     rs;
  logic [MUL_W-1:0] prod;

  // dividend: tag frame count times samples per frame, or bytes times 8
  assign prod = MUL_W'(job.frame_total) * MUL_W'(job.frame_samples);

  // one restoring step a cycle while busy
  always_comb begin
    rs = {r_r[18:0], q_r[DW-1]};
    if (rs >= {1'b0, d_r}) begin
      r_nxt = rs - {1'b0, d_r};
      q_nxt = {q_r[DW-2:0], 1'b1};
    end else begin
      r_nxt = rs;
      q_nxt = {q_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && cnt_r == CNTW'(1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= (job.method == METH_TAG) ? DW'(prod) : DW'({span, 3'b000});
      r_r <= '0;
      d_r <= job.divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  // clamp to 31 bits
  assign quotient = (|q_r[DW-1:31]) ? 31'h7FFFFFFF : q_r[30:0];
  assign done     = done_r;

endmodule

[sv/mde_checker.sv]
`include "mp3_duration_estimator_macros.svh"

module mde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] out_duration_seconds,
  input logic [1:0]  out_method
);
  import mde_pkg::*;

  logic [32:0] out_word;

  assign out_word = {out_duration_seconds, out_method};

  // a waiting result word holds
  `MDE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))
  // no input taken while a result is on offer
  `MDE_ASSERT_IMP(a_one_side, clk, rst_n, out_valid, !in_ready)
  // the last byte closes the input side
  `MDE_ASSERT_NXT(a_last_stall, clk, rst_n, in_valid && in_ready && in_last_byte, !in_ready)
  // failure reports zero
  `MDE_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_method == METH_FAIL, out_duration_seconds == 31'd0)
  // method code in range
  `MDE_ASSERT_IMP(a_meth_ok, clk, rst_n, out_valid, out_method <= METH_CBR)

endmodule

bind mp3_duration_estimator mde_checker u_mde_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .in_last_byte         (in_last_byte),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_duration_seconds (out_duration_seconds),
  .out_method           (out_method)
);
